// ----- sv/bdpc_pkg.sv -----
// bdpc_pkg: shared types and constants of the band depth pair counter
// holds transfer structs, state and control types, codes and defaults
// no dependencies
package bdpc_pkg;

  // fixed field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FIDX_W   = 8;
  localparam int unsigned SIDX_W   = 3;
  localparam int unsigned COUNT_W  = 15;
  localparam int unsigned NF_REG_W = 9;
  localparam int unsigned NS_REG_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // parameter defaults
  localparam int unsigned DEF_MAX_FUNCTIONS = 256;
  localparam int unsigned DEF_MAX_SAMPLES   = 8;

  // register reset values
  localparam logic [NF_REG_W-1:0] NF_RESET = 9'd2;
  localparam logic [NS_REG_W-1:0] NS_RESET = 4'd1;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes (word index from the bus address)
  localparam logic REG_NUM_FUNCTIONS = 1'b0;
  localparam logic REG_NUM_SAMPLES   = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic [FIDX_W-1:0]        function_index;
    logic [SIDX_W-1:0]        sample_index;
    logic signed [DATA_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [FIDX_W-1:0]  queried_function;
    logic [COUNT_W-1:0] band_count;
  } out_item_t;

  // control from the sequencer to the accumulator
  typedef struct packed {
    logic clear;
    logic pair_vld;
  } acc_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_e;

endpackage

// ----- sv/bdpc_band_acc.sv -----
// bdpc_band_acc: compares one function pair against the queried row
// and keeps the saturating band count; uses bdpc_pkg
module bdpc_band_acc #(
  parameter int unsigned MAX_SAMPLES = bdpc_pkg::DEF_MAX_SAMPLES
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  bdpc_pkg::acc_ctrl_t                            ctrl_i,
  input  logic [MAX_SAMPLES-1:0]                         mask_i,
  input  logic [MAX_SAMPLES-1:0][bdpc_pkg::DATA_W-1:0]   fv_i,
  input  logic [MAX_SAMPLES-1:0][bdpc_pkg::DATA_W-1:0]   row_a_i,
  input  logic [MAX_SAMPLES-1:0][bdpc_pkg::DATA_W-1:0]   row_b_i,
  output logic [bdpc_pkg::COUNT_W-1:0]                   count_o
);
  import bdpc_pkg::*;

  logic [MAX_SAMPLES-1:0] in_band;
  logic                   pair_holds;
  logic [COUNT_W-1:0]     count_d, count_q;

  // per sample band test, all samples side by side
  always_comb begin
    for (int s = 0; s < MAX_SAMPLES; s++) begin
      in_band[s] = !mask_i[s] ||
                   (($signed(row_a_i[s]) <= $signed(fv_i[s])) &&
                    ($signed(fv_i[s]) <= $signed(row_b_i[s]))) ||
                   (($signed(row_b_i[s]) <= $signed(fv_i[s])) &&
                    ($signed(fv_i[s]) <= $signed(row_a_i[s])));
    end
  end

  assign pair_holds = &in_band;

  // saturating pair count
  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.pair_vld && pair_holds && (count_q != COUNT_MAX)) begin
      count_d = count_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

  // the count only moves upward between clears
  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.clear |=> (count_q >= $past(count_q)))
    else $error("band count decreased without a clear");

  // a clear always empties the count
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (count_q == '0))
    else $error("band count not empty after clear");

  // no step without a pair in flight
  a_step_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctrl_i.clear && !ctrl_i.pair_vld) |=> $stable(count_q))
    else $error("band count moved with no pair compared");

endmodule

// ----- sv/band_depth_pair_counter_top.sv -----
// band_depth_pair_counter_top: value memory, pair walk sequencer, apb registers
// and output register; uses bdpc_pkg and bdpc_band_acc
//
// A load transfer writes one sample into the value memory and gives no
// result; loads are taken even while an earlier result still waits.
// A query transfer returns the number of unordered pairs of distinct functions
// among the first num_functions whose band holds the queried function at every
// used sample, num_functions being clamped to 2..MAX_FUNCTIONS. The walk visits
// one pair per cycle, reading both rows at once through the two read ports of
// the value memory and comparing all samples side by side. No other transfer
// is taken during a query. The memory has no clearing pass; samples must be
// loaded before a query reads them. Configuration must be written only while
// the block is idle; the block itself does not enforce this.
module band_depth_pair_counter_top #(
  parameter int unsigned MAX_FUNCTIONS = bdpc_pkg::DEF_MAX_FUNCTIONS,
  parameter int unsigned MAX_SAMPLES   = bdpc_pkg::DEF_MAX_SAMPLES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bdpc_pkg::in_item_t   in_data_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bdpc_pkg::out_item_t  out_data_o,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bdpc_pkg::*;

  localparam int unsigned FW = $clog2(MAX_FUNCTIONS);
  localparam int unsigned CW = $clog2(MAX_FUNCTIONS + 1);
  localparam int unsigned SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  // configuration registers
  logic [NF_REG_W-1:0] nf_reg_q;
  logic [NS_REG_W-1:0] ns_reg_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_reg_q <= NF_RESET;
      ns_reg_q <= NS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NUM_FUNCTIONS: nf_reg_q <= pwdata[NF_REG_W-1:0];
        REG_NUM_SAMPLES:   ns_reg_q <= pwdata[NS_REG_W-1:0];
        default:           ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      REG_NUM_FUNCTIONS: prdata = 32'(nf_reg_q);
      REG_NUM_SAMPLES:   prdata = 32'(ns_reg_q);
      default:           prdata = '0;
    endcase
  end

  // clamped function count and sample mask
  logic [CW-1:0]          nf_eff;
  logic [MAX_SAMPLES-1:0] smp_mask;

  always_comb begin
    if (nf_reg_q < NF_REG_W'(2)) begin
      nf_eff = CW'(2);
    end else if (32'(nf_reg_q) > MAX_FUNCTIONS) begin
      nf_eff = CW'(MAX_FUNCTIONS);
    end else begin
      nf_eff = CW'(nf_reg_q);
    end
  end

  always_comb begin
    for (int s = 0; s < MAX_SAMPLES; s++) begin
      smp_mask[s] = (s == 0) || (s < 32'(ns_reg_q));
    end
  end

  // sequencer registers
  state_e            state_q, state_d;
  logic [CW-1:0]     g_q, g_d, h_q, h_d;
  logic [FIDX_W-1:0] f_q;
  logic              f_oor_q;
  logic              fv_load_q;
  logic              pair_vld_q;
  logic              walk_last;
  logic              in_acc, is_query, is_load;
  logic              out_free;
  logic              out_load;
  acc_ctrl_t         acc_ctrl;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_query = in_acc && (in_data_i.operation == OP_QUERY);
  assign is_load  = in_acc && (in_data_i.operation == OP_LOAD);
  assign walk_last = (g_q == nf_eff - CW'(2)) && (h_q == nf_eff - CW'(1));

  // value memory: one row per function, one word per sample
  logic [MAX_SAMPLES-1:0][DATA_W-1:0] mem_q [MAX_FUNCTIONS];
  logic [MAX_SAMPLES-1:0][DATA_W-1:0] rd_a_q, rd_b_q;
  logic [MAX_SAMPLES-1:0][DATA_W-1:0] fv_q;
  logic [FW-1:0]                      in_row, addr_a, addr_b;
  logic [SW-1:0]                      in_smp;
  logic                               in_row_ok, in_smp_ok;

  assign in_row    = FW'(32'(in_data_i.function_index));
  assign in_smp    = SW'(32'(in_data_i.sample_index));
  assign in_row_ok = 32'(in_data_i.function_index) < MAX_FUNCTIONS;
  assign in_smp_ok = 32'(in_data_i.sample_index) < MAX_SAMPLES;
  assign addr_a    = (state_q == S_IDLE) ? in_row : g_q[FW-1:0];
  assign addr_b    = h_q[FW-1:0];

  // loads only land in idle, reads of a query follow later, so no overlap
  always_ff @(posedge clk_i) begin
    if (is_load && in_row_ok && in_smp_ok) begin
      mem_q[in_row][in_smp] <= in_data_i.sample_value;
    end
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
  end

  // queried row capture, zero when outside the memory
  always_ff @(posedge clk_i) begin
    if (fv_load_q) begin
      fv_q <= f_oor_q ? '0 : rd_a_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (is_query) state_d = S_WALK;
      S_WALK:  if (walk_last) state_d = S_DRAIN;
      S_DRAIN: state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o        = (state_q != S_IDLE);
    acc_ctrl.clear    = is_query;
    acc_ctrl.pair_vld = pair_vld_q;
    out_load          = (state_q == S_DONE) && out_free;
    g_d               = g_q;
    h_d               = h_q;
    unique case (state_q)
      S_IDLE: begin
        g_d = '0;
        h_d = CW'(1);
      end
      S_WALK: begin
        if (h_q == nf_eff - CW'(1)) begin
          g_d = g_q + CW'(1);
          h_d = g_q + CW'(2);
        end else begin
          h_d = h_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      g_q        <= '0;
      h_q        <= CW'(1);
      fv_load_q  <= 1'b0;
      pair_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      g_q        <= g_d;
      h_q        <= h_d;
      fv_load_q  <= is_query;
      pair_vld_q <= (state_q == S_WALK);
    end
  end

  // query identity, payload only
  always_ff @(posedge clk_i) begin
    if (is_query) begin
      f_q     <= in_data_i.function_index;
      f_oor_q <= !in_row_ok;
    end
  end

  // pair compare and count
  logic [COUNT_W-1:0] count;

  bdpc_band_acc #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .mask_i  (smp_mask),
    .fv_i    (fv_q),
    .row_a_i (rd_a_q),
    .row_b_i (rd_b_q),
    .count_o (count)
  );

  // output register
  logic      out_valid_q;
  out_item_t out_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.queried_function <= f_q;
      out_q.band_count       <= count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // every walked pair is ordered and inside the used functions
  a_pair_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> ((g_q < h_q) && (h_q < nf_eff)))
    else $error("pair walk left the used functions");

  // the last pair is still in flight while draining
  a_drain_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> pair_vld_q)
    else $error("drain without a pair in flight");

  // a query transfer starts the walk
  a_query_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_query |=> ((state_q == S_WALK) && fv_load_q))
    else $error("query transfer did not start the walk");

  // a new result appears only from the done state
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

endmodule
